// ----- src/view_matrix_lookat_defines.svh -----
// Assertion macros for the look-at view matrix block.
// Used by the checker; expects clk and arst_n in the enclosing scope.
`ifndef VIEW_MATRIX_LOOKAT_DEFINES_SVH
`define VIEW_MATRIX_LOOKAT_DEFINES_SVH

// antecedent in this cycle, consequent in the next
`define VML_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// antecedent and consequent in the same cycle
`define VML_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ----- src/vml_pkg.sv -----
// Shared constants and types of the look-at view matrix block.
// No dependencies.
package vml_pkg;
	localparam int FRAC_BITS = 16;
	localparam int DW        = 32;
	localparam int VW        = FRAC_BITS + 34;
	localparam int MW        = VW;
	localparam int SH_W      = $clog2(MW);
	localparam int NORM_TOP  = 29;
	localparam int SW        = NORM_TOP + 1;
	localparam int SQW       = 2 * SW + 2;
	localparam int RW        = SQW / 2;
	localparam int QW        = FRAC_BITS + 1;
	localparam int CW        = FRAC_BITS + 2;
	localparam int NW        = SW + FRAC_BITS + 1;
	localparam int NORM_LAT  = RW + QW + 7;

	typedef logic signed [DW-1:0] word_t;
	typedef logic signed [VW-1:0] nval_t;
	typedef logic signed [CW-1:0] cval_t;
	typedef logic [1:0]           col_t;

	localparam col_t FIRST_COL = 2'd0;
	localparam col_t LAST_COL  = 2'd3;
endpackage

// ----- src/vml_if.sv -----
// Valid/ready channel interfaces: input word (eye, target, up) and column word.
// Depends on vml_pkg.
interface vml_in_if;
	logic          valid;
	logic          ready;
	vml_pkg::word_t eye_x;
	vml_pkg::word_t eye_y;
	vml_pkg::word_t eye_z;
	vml_pkg::word_t target_x;
	vml_pkg::word_t target_y;
	vml_pkg::word_t target_z;
	vml_pkg::word_t up_x;
	vml_pkg::word_t up_y;
	vml_pkg::word_t up_z;
	modport source (output valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
		up_x, up_y, up_z, input ready);
	modport sink (input valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
		up_x, up_y, up_z, output ready);
endinterface

interface vml_out_if;
	logic           valid;
	logic           ready;
	vml_pkg::col_t  column_index;
	vml_pkg::word_t row0_value;
	vml_pkg::word_t row1_value;
	vml_pkg::word_t row2_value;
	logic           degenerate;
	logic           last_column;
	modport source (output valid, column_index, row0_value, row1_value, row2_value,
		degenerate, last_column, input ready);
	modport sink (input valid, column_index, row0_value, row1_value, row2_value,
		degenerate, last_column, output ready);
endinterface

// ----- src/vml_norm.sv -----
// Pipelined 3-vector normalizer: scale, sum of squares, digit-by-digit root,
// restoring divide with rounding. Depends on vml_pkg.
module vml_norm (
	input  logic            clk,
	input  logic            en,
	input  vml_pkg::nval_t  vec_in [3],
	output vml_pkg::cval_t  vec_out [3],
	output logic            zero_out
);
	import vml_pkg::*;

	logic [MW-1:0]   mag_c [3];
	logic [MW-1:0]   or_c;
	logic [MW-1:0]   mag_s1 [3];
	logic [2:0]      neg_s1;
	logic [MW-1:0]   or_s1;
	logic [SH_W-1:0] lead_c;
	logic [MW-1:0]   mag_s2 [3];
	logic [2:0]      neg_s2;
	logic [SH_W-1:0] lead_s2;
	logic            zero_s2;
	logic [SW-1:0]   scl_c [3];
	logic [SW-1:0]   scl_s3 [3];
	logic [2:0]      neg_s3;
	logic            zero_s3;
	logic [2*SW-1:0] sq_s4 [3];
	logic [SW-1:0]   scl_s4 [3];
	logic [2:0]      neg_s4;
	logic            zero_s4;

	// root pipeline, index 0 holds the sum of squares
	logic [RW:0]     rrem_p  [RW+1];
	logic [RW-1:0]   rroot_p [RW+1];
	logic [SQW-1:0]  rrad_p  [RW+1];
	logic [SW-1:0]   ra_p    [RW+1][3];
	logic [2:0]      rneg_p  [RW+1];
	logic            rzero_p [RW+1];
	logic [RW:0]     rrem_n  [RW];
	logic [RW-1:0]   rroot_n [RW];

	// divide pipeline, index 0 holds the prepared numerators
	logic [RW-1:0]   drem_p  [QW+1][3];
	logic [QW-1:0]   dlow_p  [QW+1][3];
	logic [QW-1:0]   dquo_p  [QW+1][3];
	logic [RW-1:0]   dlen_p  [QW+1];
	logic [2:0]      dneg_p  [QW+1];
	logic            dzero_p [QW+1];
	logic [RW-1:0]   drem_n  [QW][3];
	logic [QW-1:0]   dquo_n  [QW][3];
	logic [NW-1:0]   num_c   [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag_c[i] = vec_in[i][VW-1] ? MW'(-vec_in[i]) : MW'(vec_in[i]);
		end
		or_c = mag_c[0] | mag_c[1] | mag_c[2];
	end

	always_comb begin
		lead_c = '0;
		for (int j = 0; j < MW; j++) begin
			if (or_s1[j]) begin
				lead_c = SH_W'(j);
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (lead_s2 >= SH_W'(NORM_TOP)) begin
				scl_c[i] = SW'(mag_s2[i] >> (lead_s2 - SH_W'(NORM_TOP)));
			end else begin
				scl_c[i] = SW'(mag_s2[i] << (SH_W'(NORM_TOP) - lead_s2));
			end
		end
	end

	always_comb begin
		logic [RW+2:0] t;
		logic [RW+2:0] sub;
		for (int g = 0; g < RW; g++) begin
			t   = {rrem_p[g], rrad_p[g][SQW-1 -: 2]};
			sub = (RW+3)'({rroot_p[g], 2'b01});
			if (t >= sub) begin
				rrem_n[g]  = (RW+1)'(t - sub);
				rroot_n[g] = {rroot_p[g][RW-2:0], 1'b1};
			end else begin
				rrem_n[g]  = (RW+1)'(t);
				rroot_n[g] = {rroot_p[g][RW-2:0], 1'b0};
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			num_c[i] = NW'({ra_p[RW][i], {FRAC_BITS{1'b0}}}) + NW'(rroot_p[RW] >> 1);
		end
	end

	always_comb begin
		logic [RW:0] r2;
		for (int g = 0; g < QW; g++) begin
			for (int i = 0; i < 3; i++) begin
				r2 = {drem_p[g][i], dlow_p[g][i][QW-1]};
				if (r2 >= {1'b0, dlen_p[g]}) begin
					drem_n[g][i] = RW'(r2 - {1'b0, dlen_p[g]});
					dquo_n[g][i] = {dquo_p[g][i][QW-2:0], 1'b1};
				end else begin
					drem_n[g][i] = RW'(r2);
					dquo_n[g][i] = {dquo_p[g][i][QW-2:0], 1'b0};
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1  <= mag_c;
			or_s1   <= or_c;
			for (int i = 0; i < 3; i++) begin
				neg_s1[i] <= vec_in[i][VW-1];
			end
			mag_s2  <= mag_s1;
			neg_s2  <= neg_s1;
			lead_s2 <= lead_c;
			zero_s2 <= (or_s1 == '0);
			scl_s3  <= scl_c;
			neg_s3  <= neg_s2;
			zero_s3 <= zero_s2;
			for (int i = 0; i < 3; i++) begin
				sq_s4[i] <= (2*SW)'(scl_s3[i]) * (2*SW)'(scl_s3[i]);
			end
			scl_s4  <= scl_s3;
			neg_s4  <= neg_s3;
			zero_s4 <= zero_s3;

			rrad_p[0]  <= SQW'(sq_s4[0]) + SQW'(sq_s4[1]) + SQW'(sq_s4[2]);
			rrem_p[0]  <= '0;
			rroot_p[0] <= '0;
			ra_p[0]    <= scl_s4;
			rneg_p[0]  <= neg_s4;
			rzero_p[0] <= zero_s4;
			for (int g = 0; g < RW; g++) begin
				rrem_p[g+1]  <= rrem_n[g];
				rroot_p[g+1] <= rroot_n[g];
				rrad_p[g+1]  <= rrad_p[g] << 2;
				ra_p[g+1]    <= ra_p[g];
				rneg_p[g+1]  <= rneg_p[g];
				rzero_p[g+1] <= rzero_p[g];
			end

			for (int i = 0; i < 3; i++) begin
				drem_p[0][i] <= RW'(num_c[i] >> QW);
				dlow_p[0][i] <= num_c[i][QW-1:0];
				dquo_p[0][i] <= '0;
			end
			dlen_p[0]  <= rroot_p[RW];
			dneg_p[0]  <= rneg_p[RW];
			dzero_p[0] <= rzero_p[RW];
			for (int g = 0; g < QW; g++) begin
				for (int i = 0; i < 3; i++) begin
					drem_p[g+1][i] <= drem_n[g][i];
					dquo_p[g+1][i] <= dquo_n[g][i];
					dlow_p[g+1][i] <= dlow_p[g][i] << 1;
				end
				dlen_p[g+1]  <= dlen_p[g];
				dneg_p[g+1]  <= dneg_p[g];
				dzero_p[g+1] <= dzero_p[g];
			end

			for (int i = 0; i < 3; i++) begin
				if (dzero_p[QW]) begin
					vec_out[i] <= '0;
				end else if (dneg_p[QW][i]) begin
					vec_out[i] <= -cval_t'(dquo_p[QW][i]);
				end else begin
					vec_out[i] <= cval_t'(dquo_p[QW][i]);
				end
			end
			zero_out <= dzero_p[QW];
		end
	end
endmodule

// ----- src/view_matrix_lookat.sv -----
// Look-at view matrix builder, one input word in, four column words out.
// Throughput is set by the four-column output stage: a new word is loaded there only once the
// last column of the previous matrix is taken. The datapath itself takes a word every cycle
// while the output stage does not stall it. Stalls hold the whole pipeline.
// Reset: arst_n clears all valid bits and the output stage's busy flag and column; no clearing pass.
module view_matrix_lookat (
	input logic    clk,
	input logic    arst_n,
	vml_in_if.sink    req,
	vml_out_if.source rsp
);
	import vml_pkg::*;

	localparam int YW  = FRAC_BITS + 3;
	localparam int DSW = FRAC_BITS + 36;

	typedef logic signed [2*CW-1:0] yp_t;
	typedef logic signed [YW-1:0]   yv_t;
	typedef logic signed [DSW-1:0]  dw_t;

	localparam word_t W_MAX = {1'b0, {(DW-1){1'b1}}};
	localparam word_t W_MIN = {1'b1, {(DW-1){1'b0}}};

	function automatic dw_t rnd(input dw_t v);
		logic [DSW-1:0] m;
		m = v[DSW-1] ? DSW'(-v) : DSW'(v);
		m = (m + DSW'(1 << (FRAC_BITS - 1))) >> FRAC_BITS;
		return v[DSW-1] ? -dw_t'(m) : dw_t'(m);
	endfunction

	function automatic word_t sat(input dw_t v);
		if (v > dw_t'(W_MAX)) begin
			return W_MAX;
		end else if (v < dw_t'(W_MIN)) begin
			return W_MIN;
		end
		return word_t'(v);
	endfunction

	logic en;
	logic load;

	logic  v_s1;
	nval_t d_s1 [3];
	word_t eye_s1 [3];
	word_t up_s1 [3];

	cval_t z_n [3];
	logic  z0_n;
	logic  v_d1 [NORM_LAT];
	word_t eye_d1 [NORM_LAT][3];
	word_t up_d1 [NORM_LAT][3];

	logic  v_s2;
	nval_t prod_s2 [6];
	word_t eye_s2 [3];
	cval_t z_s2 [3];
	logic  z0_s2;

	logic  v_s3;
	nval_t c_s3 [3];
	word_t eye_s3 [3];
	cval_t z_s3 [3];
	logic  z0_s3;

	cval_t x_n [3];
	logic  x0_n;
	logic  v_d2 [NORM_LAT];
	word_t eye_d2 [NORM_LAT][3];
	cval_t z_d2 [NORM_LAT][3];
	logic  z0_d2 [NORM_LAT];

	logic  v_s4;
	yp_t   yp_s4 [6];
	nval_t dx_s4 [3];
	nval_t dz_s4 [3];
	cval_t x_s4 [3];
	cval_t z_s4 [3];
	word_t eye_s4 [3];
	logic  deg_s4;

	logic  v_s5;
	yv_t   y_s5 [3];
	dw_t   sx_s5;
	dw_t   sz_s5;
	cval_t x_s5 [3];
	cval_t z_s5 [3];
	word_t eye_s5 [3];
	logic  deg_s5;

	logic  v_s6;
	dw_t   py_s6 [3];
	word_t tx_s6;
	word_t tz_s6;
	cval_t x_s6 [3];
	yv_t   y_s6 [3];
	cval_t z_s6 [3];
	logic  deg_s6;

	logic  v_s7;
	word_t tx_s7;
	word_t ty_s7;
	word_t tz_s7;
	cval_t x_s7 [3];
	yv_t   y_s7 [3];
	cval_t z_s7 [3];
	logic  deg_s7;

	logic  busy_q;
	col_t  col_q;
	logic  deg_q;
	word_t ax_q [3];
	word_t ay_q [3];
	word_t az_q [3];
	word_t tr_q [3];

	assign load      = v_s7 && (!busy_q || (rsp.ready && col_q == LAST_COL));
	assign en        = !v_s7 || load;
	assign req.ready = en;

	vml_norm u_norm_z (
		.clk      (clk),
		.en       (en),
		.vec_in   (d_s1),
		.vec_out  (z_n),
		.zero_out (z0_n)
	);

	vml_norm u_norm_x (
		.clk      (clk),
		.en       (en),
		.vec_in   (c_s3),
		.vec_out  (x_n),
		.zero_out (x0_n)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			for (int g = 0; g < NORM_LAT; g++) begin
				v_d1[g] <= 1'b0;
				v_d2[g] <= 1'b0;
			end
		end else if (en) begin
			v_s1    <= req.valid;
			v_d1[0] <= v_s1;
			v_d2[0] <= v_s3;
			for (int g = 1; g < NORM_LAT; g++) begin
				v_d1[g] <= v_d1[g-1];
				v_d2[g] <= v_d2[g-1];
			end
			v_s2 <= v_d1[NORM_LAT-1];
			v_s3 <= v_s2;
			v_s4 <= v_d2[NORM_LAT-1];
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1[0]   <= nval_t'(req.eye_x) - nval_t'(req.target_x);
			d_s1[1]   <= nval_t'(req.eye_y) - nval_t'(req.target_y);
			d_s1[2]   <= nval_t'(req.eye_z) - nval_t'(req.target_z);
			eye_s1[0] <= req.eye_x;
			eye_s1[1] <= req.eye_y;
			eye_s1[2] <= req.eye_z;
			up_s1[0]  <= req.up_x;
			up_s1[1]  <= req.up_y;
			up_s1[2]  <= req.up_z;

			eye_d1[0] <= eye_s1;
			up_d1[0]  <= up_s1;
			for (int g = 1; g < NORM_LAT; g++) begin
				eye_d1[g] <= eye_d1[g-1];
				up_d1[g]  <= up_d1[g-1];
			end

			// up x z
			prod_s2[0] <= nval_t'(up_d1[NORM_LAT-1][1]) * nval_t'(z_n[2]);
			prod_s2[1] <= nval_t'(up_d1[NORM_LAT-1][2]) * nval_t'(z_n[1]);
			prod_s2[2] <= nval_t'(up_d1[NORM_LAT-1][2]) * nval_t'(z_n[0]);
			prod_s2[3] <= nval_t'(up_d1[NORM_LAT-1][0]) * nval_t'(z_n[2]);
			prod_s2[4] <= nval_t'(up_d1[NORM_LAT-1][0]) * nval_t'(z_n[1]);
			prod_s2[5] <= nval_t'(up_d1[NORM_LAT-1][1]) * nval_t'(z_n[0]);
			eye_s2     <= eye_d1[NORM_LAT-1];
			z_s2       <= z_n;
			z0_s2      <= z0_n;

			for (int i = 0; i < 3; i++) begin
				c_s3[i] <= prod_s2[2*i] - prod_s2[2*i+1];
			end
			eye_s3 <= eye_s2;
			z_s3   <= z_s2;
			z0_s3  <= z0_s2;

			eye_d2[0] <= eye_s3;
			z_d2[0]   <= z_s3;
			z0_d2[0]  <= z0_s3;
			for (int g = 1; g < NORM_LAT; g++) begin
				eye_d2[g] <= eye_d2[g-1];
				z_d2[g]   <= z_d2[g-1];
				z0_d2[g]  <= z0_d2[g-1];
			end

			// z x x, and the x and z dot products with eye
			yp_s4[0] <= yp_t'(z_d2[NORM_LAT-1][1]) * yp_t'(x_n[2]);
			yp_s4[1] <= yp_t'(z_d2[NORM_LAT-1][2]) * yp_t'(x_n[1]);
			yp_s4[2] <= yp_t'(z_d2[NORM_LAT-1][2]) * yp_t'(x_n[0]);
			yp_s4[3] <= yp_t'(z_d2[NORM_LAT-1][0]) * yp_t'(x_n[2]);
			yp_s4[4] <= yp_t'(z_d2[NORM_LAT-1][0]) * yp_t'(x_n[1]);
			yp_s4[5] <= yp_t'(z_d2[NORM_LAT-1][1]) * yp_t'(x_n[0]);
			for (int i = 0; i < 3; i++) begin
				dx_s4[i] <= nval_t'(x_n[i]) * nval_t'(eye_d2[NORM_LAT-1][i]);
				dz_s4[i] <= nval_t'(z_d2[NORM_LAT-1][i]) * nval_t'(eye_d2[NORM_LAT-1][i]);
			end
			x_s4   <= x_n;
			z_s4   <= z_d2[NORM_LAT-1];
			eye_s4 <= eye_d2[NORM_LAT-1];
			deg_s4 <= z0_d2[NORM_LAT-1] | x0_n;

			for (int i = 0; i < 3; i++) begin
				y_s5[i] <= yv_t'(rnd(dw_t'(yp_s4[2*i]) - dw_t'(yp_s4[2*i+1])));
			end
			sx_s5  <= dw_t'(dx_s4[0]) + dw_t'(dx_s4[1]) + dw_t'(dx_s4[2]);
			sz_s5  <= dw_t'(dz_s4[0]) + dw_t'(dz_s4[1]) + dw_t'(dz_s4[2]);
			x_s5   <= x_s4;
			z_s5   <= z_s4;
			eye_s5 <= eye_s4;
			deg_s5 <= deg_s4;

			for (int i = 0; i < 3; i++) begin
				py_s6[i] <= dw_t'(y_s5[i]) * dw_t'(eye_s5[i]);
			end
			tx_s6  <= sat(-rnd(sx_s5));
			tz_s6  <= sat(-rnd(sz_s5));
			x_s6   <= x_s5;
			y_s6   <= y_s5;
			z_s6   <= z_s5;
			deg_s6 <= deg_s5;

			ty_s7  <= sat(-rnd(py_s6[0] + py_s6[1] + py_s6[2]));
			tx_s7  <= tx_s6;
			tz_s7  <= tz_s6;
			x_s7   <= x_s6;
			y_s7   <= y_s6;
			z_s7   <= z_s6;
			deg_s7 <= deg_s6;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			col_q  <= FIRST_COL;
		end else if (load) begin
			busy_q <= 1'b1;
			col_q  <= FIRST_COL;
		end else if (busy_q && rsp.ready) begin
			if (col_q == LAST_COL) begin
				busy_q <= 1'b0;
			end
			col_q <= col_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			deg_q <= deg_s7;
			for (int i = 0; i < 3; i++) begin
				ax_q[i] <= word_t'(x_s7[i]);
				ay_q[i] <= word_t'(y_s7[i]);
				az_q[i] <= word_t'(z_s7[i]);
			end
			tr_q[0] <= tx_s7;
			tr_q[1] <= ty_s7;
			tr_q[2] <= tz_s7;
		end
	end

	always_comb begin
		rsp.valid        = busy_q;
		rsp.column_index = col_q;
		rsp.degenerate   = deg_q;
		rsp.last_column  = (col_q == LAST_COL);
		case (col_q)
			2'd0: begin
				rsp.row0_value = ax_q[0];
				rsp.row1_value = ay_q[0];
				rsp.row2_value = az_q[0];
			end
			2'd1: begin
				rsp.row0_value = ax_q[1];
				rsp.row1_value = ay_q[1];
				rsp.row2_value = az_q[1];
			end
			2'd2: begin
				rsp.row0_value = ax_q[2];
				rsp.row1_value = ay_q[2];
				rsp.row2_value = az_q[2];
			end
			default: begin
				rsp.row0_value = tr_q[0];
				rsp.row1_value = tr_q[1];
				rsp.row2_value = tr_q[2];
			end
		endcase
	end
endmodule

// ----- src/vml_checker.sv -----
// Port-level checks on the column word stream of view_matrix_lookat.
// Depends on view_matrix_lookat_defines.svh; bound to the top level below.
`include "view_matrix_lookat_defines.svh"

module vml_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input logic [1:0] column_index,
	input logic degenerate,
	input logic last_column
);
	`VML_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(column_index), "stalled column word changed")
	`VML_ASSERT_NEXT(a_col_step, out_valid && out_ready && !last_column, out_valid && column_index == $past(column_index) + 2'd1 && degenerate == $past(degenerate), "column sequence broken")
	`VML_ASSERT_NOW(a_last, out_valid, last_column == (column_index == 2'd3), "last flag off column 3")
	`VML_ASSERT_NEXT(a_restart, out_valid && out_ready && last_column, !out_valid || column_index == 2'd0, "new matrix not at column 0")
endmodule

bind view_matrix_lookat vml_checker u_vml_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (rsp.valid),
	.out_ready    (rsp.ready),
	.column_index (rsp.column_index),
	.degenerate   (rsp.degenerate),
	.last_column  (rsp.last_column)
);
